// File: src/ppp_pkg.sv
`timescale 1ns / 1ps
// shared constants, register codes and types of the payload pattern patcher
package ppp_pkg;

    localparam int WIN_DEPTH = 64;
    localparam int WIN_CELLS = WIN_DEPTH - 1;
    localparam int CELL_W    = $clog2(WIN_CELLS);
    localparam int MATCH_MAX = 8;
    localparam int MIDX_W    = (MATCH_MAX > 1) ? $clog2(MATCH_MAX) : 1;
    localparam int PATCH_MAX = 8;
    localparam int PIDX_W    = (PATCH_MAX > 1) ? $clog2(PATCH_MAX) : 1;
    localparam int LEN_W     = 4;
    localparam int OFF_W     = 6;
    localparam int BASE_W    = 8;
    localparam int POS_W     = 16;
    localparam int DIFF_W    = POS_W + 2;
    localparam int SKIP_W    = 3;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int IDX_LSB   = 3;

    typedef enum logic [ADDR_W-IDX_LSB-1:0] {
        REG_MATCH_PATTERN = 3'd0,
        REG_MATCH_LENGTH  = 3'd1,
        REG_PATCH_BYTES   = 3'd2,
        REG_PATCH_LENGTH  = 3'd3,
        REG_PATCH_OFFSET  = 3'd4,
        REG_REPLACE_ALL   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [63:0]      match_pattern;
        logic [LEN_W-1:0] match_length;
        logic [63:0]      patch_bytes;
        logic [LEN_W-1:0] patch_length;
        logic [OFF_W-1:0] patch_offset;
        logic             replace_all;
    } t_cfg;

    // one byte slot of the window or of the pending patch line
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_slot;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out;

    // broadcast from the matcher to every cell; base is signed
    typedef struct packed {
        logic                       apply;
        logic [BASE_W-1:0]          base;
        logic [LEN_W-1:0]           plen;
        logic [PATCH_MAX-1:0][7:0]  bytes;
    } t_patch_ctl;

endpackage

// File: src/payload_pattern_patcher_top.sv
`timescale 1ns / 1ps
// top level of the payload pattern patcher: cell chain, matcher, output buffer, registers
//
// channel   dir  handshake               payload
// s_axis    in   tvalid / tready         tdata[7:0] payload_byte, tlast last_byte
// m_axis    out  tvalid / tready         tdata[7:0] out_byte, tlast out_last
// apb cfg   in   psel, penable, pwrite   paddr[5:0], pwdata[63:0], prdata[63:0]
//
// one request per cycle while s_axis_tready is high; compare and patch settle in that cycle
// a byte leaves once 63 newer bytes have pushed it along the 63-cell chain
// after a request with tlast the chain drains, with s_axis held off
// m_axis stalls hold off s_axis only while the chain is full and the skid entry is taken
// synchronous active-low reset clears valid bits, pending patches and search state
module payload_pattern_patcher_top
    import ppp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] payload_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg                   w_cfg;
    t_patch_ctl             w_ctl;
    t_slot [WIN_CELLS-1:0]  w_win;
    t_slot [WIN_CELLS-1:0]  w_win_in;
    t_slot [WIN_CELLS-1:0]  w_pend;
    t_slot [WIN_CELLS-1:0]  w_pend_in;
    t_slot                  w_new;
    t_out                   w_out;
    t_out                   w_obuf_data;
    logic                   r_flush;
    logic                   n_flush;
    logic                   w_room;
    logic                   w_full;
    logic                   w_accept;
    logic                   w_flush_step;
    logic                   w_flush_done;
    logic                   w_shift;
    logic                   w_push;

    ppp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_full        = w_win[WIN_CELLS-1].valid;
    assign s_axis_tready = !r_flush && (!w_full || w_room);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_flush_step  = r_flush && (!w_full || w_room);
    assign w_shift       = w_accept || w_flush_step;
    assign w_push        = w_shift && w_full;
    assign w_flush_done  = w_flush_step && w_full && !w_win[WIN_CELLS-2].valid;

    // a pending patch replaces the arriving byte
    assign w_new.valid = w_accept;
    assign w_new.data  = w_pend[0].valid ? w_pend[0].data : s_axis_tdata;

    assign w_win_in  = {w_win[WIN_CELLS-2:0], w_new};
    assign w_pend_in = {t_slot'('0), w_pend[WIN_CELLS-1:1]};

    ppp_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_last  (s_axis_tlast),
        .i_cfg   (w_cfg),
        .i_win   (w_win_in[MATCH_MAX-1:0]),
        .o_ctl   (w_ctl)
    );

    for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
        ppp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (CELL_W'(k)),
            .i_win_shift  (w_shift),
            .i_pend_shift (w_accept),
            .i_pend_clr   (w_accept && s_axis_tlast),
            .i_win_in     (w_win_in[k]),
            .i_pend_in    (w_pend_in[k]),
            .i_ctl        (w_ctl),
            .o_win        (w_win[k]),
            .o_pend       (w_pend[k])
        );
    end

    // final byte of the drain is the one with nothing valid behind it
    assign w_out.data = w_win[WIN_CELLS-1].data;
    assign w_out.last = r_flush && !w_win[WIN_CELLS-2].valid;

    ppp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_out),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .o_data  (w_obuf_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_obuf_data.data;
    assign m_axis_tlast = w_obuf_data.last;

    always_comb begin
        n_flush = r_flush;
        if (w_accept && s_axis_tlast) begin
            n_flush = 1'b1;
        end else if (w_flush_done) begin
            n_flush = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush <= 1'b0;
        end else begin
            r_flush <= n_flush;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !s_axis_tready)
        else $error("input accepted while the chain drains");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_room)
        else $error("output buffer overrun");

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> r_flush)
        else $error("drain did not start after last byte");

    a_drain_leaves_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flush_done |=> (!r_flush && !w_win[0].valid))
        else $error("chain not empty after drain");
`endif

endmodule

// File: src/ppp_regs.sv
`timescale 1ns / 1ps
// configuration register file with its apb-style port
module ppp_regs
    import ppp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                         r_cfg;
    t_cfg                         n_cfg;
    logic [ADDR_W-IDX_LSB-1:0]    w_idx;
    logic                         w_wr;

    assign w_idx  = paddr[ADDR_W-1:IDX_LSB];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_MATCH_PATTERN: n_cfg.match_pattern = pwdata;
                REG_MATCH_LENGTH:  n_cfg.match_length  = pwdata[LEN_W-1:0];
                REG_PATCH_BYTES:   n_cfg.patch_bytes   = pwdata;
                REG_PATCH_LENGTH:  n_cfg.patch_length  = pwdata[LEN_W-1:0];
                REG_PATCH_OFFSET:  n_cfg.patch_offset  = pwdata[OFF_W-1:0];
                REG_REPLACE_ALL:   n_cfg.replace_all   = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_pattern <= '0;
            r_cfg.match_length  <= LEN_W'(1);
            r_cfg.patch_bytes   <= '0;
            r_cfg.patch_length  <= '0;
            r_cfg.patch_offset  <= '0;
            r_cfg.replace_all   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MATCH_PATTERN: prdata = r_cfg.match_pattern;
            REG_MATCH_LENGTH:  prdata = DATA_W'(r_cfg.match_length);
            REG_PATCH_BYTES:   prdata = r_cfg.patch_bytes;
            REG_PATCH_LENGTH:  prdata = DATA_W'(r_cfg.patch_length);
            REG_PATCH_OFFSET:  prdata = DATA_W'(r_cfg.patch_offset);
            REG_REPLACE_ALL:   prdata = DATA_W'(r_cfg.replace_all);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: src/ppp_cell.sv
`timescale 1ns / 1ps
// one window cell: a window byte moving up the chain and a pending patch moving down
module ppp_cell
    import ppp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_index,
    input  logic              i_win_shift,
    input  logic              i_pend_shift,
    input  logic              i_pend_clr,
    input  t_slot             i_win_in,
    input  t_slot             i_pend_in,
    input  t_patch_ctl        i_ctl,
    output t_slot             o_win,
    output t_slot             o_pend
);

    logic              r_win_valid;
    logic [7:0]        r_win_data;
    logic              r_pend_valid;
    logic [7:0]        r_pend_data;
    logic [BASE_W-1:0] w_jw;
    logic [BASE_W-1:0] w_jp;
    logic              w_win_wr;
    logic              w_pend_wr;
    logic [7:0]        n_win_data;
    logic [7:0]        n_pend_data;

    // patch byte index landing here: base - index in the window,
    // base + 1 + index in the pending line
    assign w_jw = i_ctl.base - BASE_W'(i_index);
    assign w_jp = i_ctl.base + BASE_W'(1) + BASE_W'(i_index);

    assign w_win_wr  = i_ctl.apply && i_win_in.valid && !w_jw[BASE_W-1]
                       && (w_jw < BASE_W'(i_ctl.plen));
    assign w_pend_wr = i_ctl.apply && !w_jp[BASE_W-1]
                       && (w_jp < BASE_W'(i_ctl.plen));

    assign n_win_data  = w_win_wr  ? i_ctl.bytes[w_jw[PIDX_W-1:0]] : i_win_in.data;
    assign n_pend_data = w_pend_wr ? i_ctl.bytes[w_jp[PIDX_W-1:0]] : i_pend_in.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_win_shift) begin
                r_win_valid <= i_win_in.valid;
            end
            if (i_pend_clr) begin
                r_pend_valid <= 1'b0;
            end else if (i_pend_shift) begin
                r_pend_valid <= w_pend_wr || i_pend_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_win_shift) begin
            r_win_data <= n_win_data;
        end
        if (i_pend_shift) begin
            r_pend_data <= n_pend_data;
        end
    end

    assign o_win  = '{valid: r_win_valid,  data: r_win_data};
    assign o_pend = '{valid: r_pend_valid, data: r_pend_data};

endmodule

// File: src/ppp_match.sv
`timescale 1ns / 1ps
// pattern compare on the newest window bytes and search state
module ppp_match
    import ppp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_last,
    input  t_cfg                       i_cfg,
    input  t_slot [MATCH_MAX-1:0]      i_win,
    output t_patch_ctl                 o_ctl
);

    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            n_pos;
    logic [SKIP_W-1:0]           r_skip;
    logic [SKIP_W-1:0]           n_skip;
    logic                        r_stop;
    logic                        n_stop;
    logic [LEN_W-1:0]            w_mlen;
    logic [LEN_W-1:0]            w_plen;
    logic [MATCH_MAX-1:0][7:0]   w_pat;
    logic                        w_hit;
    logic [BASE_W-1:0]           w_base;
    logic [DIFF_W-1:0]           w_diff;
    logic                        w_before;
    logic                        w_apply;

    assign w_pat = i_cfg.match_pattern[8*MATCH_MAX-1:0];

    always_comb begin
        if (i_cfg.match_length == '0) begin
            w_mlen = LEN_W'(1);
        end else if (i_cfg.match_length > LEN_W'(MATCH_MAX)) begin
            w_mlen = LEN_W'(MATCH_MAX);
        end else begin
            w_mlen = i_cfg.match_length;
        end
    end

    assign w_plen = (i_cfg.patch_length > LEN_W'(PATCH_MAX)) ? LEN_W'(PATCH_MAX)
                                                             : i_cfg.patch_length;

    // window byte k is compared with pattern byte mlen-1-k
    always_comb begin
        logic [LEN_W-1:0] v_idx;
        w_hit = 1'b1;
        v_idx = '0;
        for (int k = 0; k < MATCH_MAX; k++) begin
            v_idx = w_mlen - LEN_W'(1) - LEN_W'(k);
            if (LEN_W'(k) < w_mlen) begin
                if (!i_win[k].valid || (i_win[k].data != w_pat[v_idx[MIDX_W-1:0]])) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    // base = mlen - 1 - offset, signed
    assign w_base = BASE_W'(w_mlen) - BASE_W'(1)
                    - {{(BASE_W-OFF_W){i_cfg.patch_offset[OFF_W-1]}}, i_cfg.patch_offset};

    // match whose writes all fall before the packet start
    assign w_diff   = {{(DIFF_W-BASE_W){w_base[BASE_W-1]}}, w_base} - DIFF_W'(r_pos);
    assign w_before = !w_diff[DIFF_W-1] && (w_diff >= DIFF_W'(w_plen));

    assign w_apply = i_step && (r_skip == '0) && !r_stop && w_hit && !w_before;

    assign o_ctl.apply = w_apply;
    assign o_ctl.base  = w_base;
    assign o_ctl.plen  = w_plen;
    assign o_ctl.bytes = i_cfg.patch_bytes[8*PATCH_MAX-1:0];

    always_comb begin
        n_pos  = r_pos;
        n_skip = r_skip;
        n_stop = r_stop;
        if (i_step) begin
            if (i_last) begin
                n_pos  = '0;
                n_skip = '0;
                n_stop = 1'b0;
            end else begin
                if (r_pos != '1) begin
                    n_pos = r_pos + POS_W'(1);
                end
                if (r_skip != '0) begin
                    n_skip = r_skip - SKIP_W'(1);
                end else if (w_apply) begin
                    if (i_cfg.replace_all) begin
                        n_skip = SKIP_W'(w_mlen - LEN_W'(1));
                    end else begin
                        n_stop = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_skip <= '0;
            r_stop <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_skip <= n_skip;
            r_stop <= n_stop;
        end
    end

endmodule

// File: src/ppp_obuf.sv
`timescale 1ns / 1ps
// two-entry output buffer: output register plus skid entry
module ppp_obuf
    import ppp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    output logic o_room,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    logic r_main_valid;
    logic r_skid_valid;
    t_out r_main;
    t_out r_skid;
    logic w_pop;

    assign w_pop   = r_main_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= i_push;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end else if (!r_main_valid) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
